@@ sv/q6k_block_dot_product_macros.svh @@
// Assertion helpers used by q6k_block_dot_product.sv to check this block.
`ifndef Q6K_BLOCK_DOT_PRODUCT_MACROS_SVH
`define Q6K_BLOCK_DOT_PRODUCT_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define Q6K_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define Q6K_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/q6k_pkg.sv @@
package q6k_pkg;

    localparam logic [7:0] QH_BASE = 8'd128;
    localparam logic [7:0] SC_BASE = 8'd192;
    localparam logic [7:0] D_BASE  = 8'd208;
    localparam logic [7:0] D_HIGH  = 8'd209;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

    // One activation after decode, handed from the front to the back.
    typedef struct packed {
        logic signed [7:0] sc;
        logic [5:0]        qraw;
        logic [15:0]       d_half;
        logic [31:0]       x;
        logic              last;
    } q6k_work_t;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [10:0] mn;
        logic [3:0]  s;
        logic [31:0] r;
        e  = h[14:10];
        mn = {1'b0, h[9:0]};
        s  = '0;
        r  = '0;
        if (e == 5'd0) begin
            if (h[9:0] == 10'd0) begin
                r = {h[15], 31'b0};
            end
            else begin
                for (int k = 0; k < 10; k++) begin
                    if (!mn[10]) begin
                        mn = {mn[9:0], 1'b0};
                        s  = s + 4'd1;
                    end
                end
                r = {h[15], 8'd113 - {4'b0, s}, mn[9:0], 13'b0};
            end
        end
        else if (e == 5'h1F) begin
            r = {h[15], 8'hFF, h[9:0], 13'b0};
        end
        else begin
            r = {h[15], {3'b0, e} + 8'd112, h[9:0], 13'b0};
        end
        return r;
    endfunction

    function automatic logic [31:0] int8_to_single(input logic [7:0] v);
        logic [7:0]  mag;
        logic [2:0]  p;
        logic [30:0] wide;
        logic [31:0] r;
        mag  = v[7] ? (~v + 8'd1) : v;
        p    = '0;
        for (int k = 0; k < 8; k++) begin
            if (mag[k]) begin
                p = 3'(k);
            end
        end
        wide = {23'b0, mag} << (5'd23 - {2'b0, p});
        r    = (mag == 8'd0) ? 32'd0 : {v[7], 8'd127 + {5'b0, p}, wide[22:0]};
        return r;
    endfunction

    // IEEE single multiply, round to nearest even, first NaN operand wins.
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sr;
        logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0]         ea, eb, eu;
        logic [23:0]        ma, mb, m;
        logic [47:0]        p, pn, ext;
        logic [5:0]         lz, sh;
        logic signed [10:0] er, shv;
        logic               sticky, rb, sb, rup;
        logic [31:0]        pk, res;
        sr     = a[31] ^ b[31];
        a_nan  = (&a[30:23]) && (|a[22:0]);
        b_nan  = (&b[30:23]) && (|b[22:0]);
        a_inf  = (&a[30:23]) && !(|a[22:0]);
        b_inf  = (&b[30:23]) && !(|b[22:0]);
        a_zero = !(|a[30:0]);
        b_zero = !(|b[30:0]);
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        p      = ma * mb;
        lz     = '0;
        for (int k = 0; k < 48; k++) begin
            if (p[k]) begin
                lz = 6'(47 - k);
            end
        end
        pn  = p << lz;
        er  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126 - $signed({5'b0, lz});
        shv = 11'sd1 - er;
        if (er <= 11'sd0) begin
            sh     = (shv >= 11'sd48) ? 6'd48 : shv[5:0];
            ext    = pn >> sh;
            sticky = |(pn & ~({48{1'b1}} << sh));
            eu     = 8'd0;
        end
        else begin
            sh     = '0;
            ext    = pn;
            sticky = 1'b0;
            eu     = er[7:0];
        end
        m   = ext[47:24];
        rb  = ext[23];
        sb  = (|ext[22:0]) | sticky | (sh != 6'd0 && 1'b0);
        rup = rb & (sb | m[0]);
        pk  = {1'b0, eu, m[22:0]} + {31'b0, rup};
        if (a_nan) begin
            res = a | FP_QUIET_BIT;
        end
        else if (b_nan) begin
            res = b | FP_QUIET_BIT;
        end
        else if (a_inf || b_inf) begin
            res = (a_zero || b_zero) ? FP_DEFAULT_NAN : {sr, 8'hFF, 23'b0};
        end
        else if (a_zero || b_zero) begin
            res = {sr, 31'b0};
        end
        else if (er >= 11'sd255) begin
            res = {sr, 8'hFF, 23'b0};
        end
        else begin
            res = {sr, pk[30:0]};
        end
        return res;
    endfunction

    // IEEE single add, round to nearest even, first NaN operand wins.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [31:0] big, sml, pk, res;
        logic [7:0]  ebg, esm, dexp, lim;
        logic [26:0] mbg, msm, msh, mn;
        logic [27:0] sum;
        logic [4:0]  lz, shl;
        logic [8:0]  e;
        logic        sticky, rb, sb, rup;
        a_nan  = (&a[30:23]) && (|a[22:0]);
        b_nan  = (&b[30:23]) && (|b[22:0]);
        a_inf  = (&a[30:23]) && !(|a[22:0]);
        b_inf  = (&b[30:23]) && !(|b[22:0]);
        a_zero = !(|a[30:0]);
        b_zero = !(|b[30:0]);
        if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
        end
        else begin
            big = b;
            sml = a;
        end
        ebg  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        esm  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbg  = {big[30:23] != 8'd0, big[22:0], 3'b0};
        msm  = {sml[30:23] != 8'd0, sml[22:0], 3'b0};
        dexp = ebg - esm;
        if (dexp >= 8'd27) begin
            msh    = '0;
            sticky = |msm;
        end
        else begin
            msh    = msm >> dexp[4:0];
            sticky = |(msm & ~({27{1'b1}} << dexp[4:0]));
        end
        msh[0] = msh[0] | sticky;
        sum    = (a[31] ^ b[31]) ? ({1'b0, mbg} - {1'b0, msh}) : ({1'b0, mbg} + {1'b0, msh});
        lz     = '0;
        for (int k = 0; k < 27; k++) begin
            if (sum[k]) begin
                lz = 5'(26 - k);
            end
        end
        lim = ebg - 8'd1;
        if (sum[27]) begin
            mn  = {sum[27:2], sum[1] | sum[0]};
            e   = {1'b0, ebg} + 9'd1;
            shl = '0;
        end
        else begin
            shl = ({3'b0, lz} < lim) ? lz : lim[4:0];
            mn  = sum[26:0] << shl;
            e   = mn[26] ? ({1'b0, ebg} - {4'b0, shl}) : 9'd0;
        end
        rb  = mn[2];
        sb  = |mn[1:0];
        rup = rb & (sb | mn[3]);
        pk  = {1'b0, e[7:0], mn[25:3]} + {31'b0, rup};
        if (a_nan) begin
            res = a | FP_QUIET_BIT;
        end
        else if (b_nan) begin
            res = b | FP_QUIET_BIT;
        end
        else if (a_inf && b_inf) begin
            res = (a[31] != b[31]) ? FP_DEFAULT_NAN : a;
        end
        else if (a_inf) begin
            res = a;
        end
        else if (b_inf) begin
            res = b;
        end
        else if (a_zero && b_zero) begin
            res = {a[31] & b[31], 31'b0};
        end
        else if (a_zero) begin
            res = b;
        end
        else if (b_zero) begin
            res = a;
        end
        else if (sum == 28'd0) begin
            res = 32'd0;
        end
        else if (e >= 9'd255) begin
            res = {big[31], 8'hFF, 23'b0};
        end
        else begin
            res = {big[31], pk[30:0]};
        end
        return res;
    endfunction

endpackage

@@ sv/q6k_if.sv @@
interface q6k_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic [7:0]  element_index;
    logic [31:0] activation_bits;
    logic        last_of_row;

    modport source (output valid, func, byte_index, byte_value, element_index,
                    activation_bits, last_of_row, input ready);
    modport sink (input valid, func, byte_index, byte_value, element_index,
                  activation_bits, last_of_row, output ready);
endinterface

interface q6k_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_sum_bits;

    modport source (output valid, row_sum_bits, input ready);
    modport sink (input valid, row_sum_bits, output ready);
endinterface

@@ sv/q6k_block_dot_product.sv @@
// Block byte writes are taken one per cycle whenever the front stage is empty or can pass its item to the queue.
// An activation steps the arithmetic sequencer through fetch, three float
// multiplies through one shared multiplier and the float add, then, on
// last_of_row, an emit state that waits until the output register is free;
// the sequencer takes the next activation only once it is back in idle.
// Reset clears the row sum to +0.0, the queue and all handshakes; block bytes
// hold whatever was there until they are written.
`include "q6k_block_dot_product_macros.svh"

module q6k_block_dot_product
    import q6k_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    q6k_in_if.sink    in_ch,
    q6k_out_if.source out_ch
);

    // The front stores block bytes and, for an activation, reads the low
    // nibble, high pair, scale and super-scale of that element together into
    // registers, then packs the rebuilt 6-bit weight into a work item.
    q6k_work_t front_ent;
    q6k_work_t queue_ent;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;

    q6k_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .ent    (front_ent)
    );

    // A two-entry queue lets the front keep taking byte writes and decoding
    // the next activation while the back is still busy with arithmetic.
    q6k_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_ent),
        .pop   (pop),
        .dout  (queue_ent),
        .full  (q_full),
        .empty (q_empty)
    );

    // The back widens the fp16 super-scale, forms d*scale, then times the
    // weight, then times the activation, rounding each product to float32,
    // and adds the result into the row accumulator. The output register lets
    // the next item start while a finished row sum waits to be taken.
    q6k_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ent     (queue_ent),
        .q_empty (q_empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

    `Q6K_ASSERT_IMP(a_pop_not_empty, pop, !q_empty, "queue popped while empty")
    `Q6K_ASSERT_IMP(a_push_has_room, push && !pop, !q_full, "queue pushed while full")
    `Q6K_ASSERT_NXT(a_pop_spaced, pop, !pop, "back popped two items in a row")

endmodule

@@ sv/q6k_front.sv @@
module q6k_front
    import q6k_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    q6k_in_if.sink    in_ch,
    input  logic      q_full,
    output logic      push,
    output q6k_work_t ent
);

    logic [7:0]  qmem [0:191];
    logic [7:0]  sc_reg [16];
    logic [7:0]  d_lo_reg;
    logic [7:0]  d_hi_reg;
    logic [7:0]  lo_rd_reg;
    logic [7:0]  hi_rd_reg;
    logic [7:0]  sc_cap_reg;
    logic [15:0] d_cap_reg;
    logic [31:0] x_cap_reg;
    logic        last_cap_reg;
    logic        lo_sh_reg;
    logic [1:0]  hi_sh_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        accept;
    logic        act;
    logic [7:0]  idx;
    logic [7:0]  lo_addr;
    logic [7:0]  hi_addr;
    logic [7:0]  hi_byte;

    assign accept = in_ch.valid && in_ch.ready;
    assign act    = accept && in_ch.func;
    assign idx    = in_ch.element_index;
    assign in_ch.ready = !s1_valid_reg || !q_full;
    assign push   = s1_valid_reg && !q_full;

    // Low nibbles sit in 0..127, high bit pairs in 128..191.
    assign lo_addr = {1'b0, idx[7], idx[5:0]};
    assign hi_addr = QH_BASE | {2'b0, idx[7], idx[4:0]};

    always_ff @(posedge clk)
    begin
        if (accept && !in_ch.func && in_ch.byte_index < SC_BASE)
        begin
            qmem[in_ch.byte_index] <= in_ch.byte_value;
        end
        if (act)
        begin
            lo_rd_reg <= qmem[lo_addr];
            hi_rd_reg <= qmem[hi_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !in_ch.func)
        begin
            if (in_ch.byte_index >= SC_BASE && in_ch.byte_index < D_BASE)
            begin
                sc_reg[in_ch.byte_index[3:0]] <= in_ch.byte_value;
            end
            if (in_ch.byte_index == D_BASE)
            begin
                d_lo_reg <= in_ch.byte_value;
            end
            if (in_ch.byte_index == D_HIGH)
            begin
                d_hi_reg <= in_ch.byte_value;
            end
        end
        if (act)
        begin
            sc_cap_reg   <= sc_reg[idx[7:4]];
            d_cap_reg    <= {d_hi_reg, d_lo_reg};
            x_cap_reg    <= in_ch.activation_bits;
            last_cap_reg <= in_ch.last_of_row;
            lo_sh_reg    <= idx[6];
            hi_sh_reg    <= idx[6:5];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (push)
        begin
            s1_valid_next = 1'b0;
        end
        if (act)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign hi_byte = hi_rd_reg >> {hi_sh_reg, 1'b0};

    always_comb
    begin
        ent.sc     = sc_cap_reg;
        ent.qraw   = {hi_byte[1:0], lo_sh_reg ? lo_rd_reg[7:4] : lo_rd_reg[3:0]};
        ent.d_half = d_cap_reg;
        ent.x      = x_cap_reg;
        ent.last   = last_cap_reg;
    end

endmodule

@@ sv/q6k_queue.sv @@
module q6k_queue
    import q6k_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q6k_work_t din,
    input  logic      pop,
    output q6k_work_t dout,
    output logic      full,
    output logic      empty
);

    q6k_work_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ push;
            rd_ptr_reg <= rd_ptr_reg ^ pop;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/q6k_back.sv @@
module q6k_back
    import q6k_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q6k_work_t ent,
    input  logic      q_empty,
    output logic      pop,
    q6k_out_if.source out_ch
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_M1   = 6'b000010,
        S_M2   = 6'b000100,
        S_M3   = 6'b001000,
        S_ADD  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    q6k_work_t   ent_reg, ent_next;
    logic [31:0] work_reg, work_next;
    logic [31:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_bits_reg, out_bits_next;
    logic [7:0]  q_signed;
    logic [31:0] mul_b;
    logic [31:0] mul_y;

    assign q_signed = {2'b0, ent_reg.qraw} - 8'd32;

    always_comb
    begin
        case (state_reg)
            S_M1:    mul_b = int8_to_single(ent_reg.sc);
            S_M2:    mul_b = int8_to_single(q_signed);
            default: mul_b = ent_reg.x;
        endcase
    end

    // One shared multiplier serves all three products.
    assign mul_y = fp_mul(work_reg, mul_b);

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        work_next      = work_reg;
        acc_next       = acc_reg;
        out_bits_next  = out_bits_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        pop            = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    ent_next   = ent;
                    work_next  = half_to_single(ent.d_half);
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                work_next  = mul_y;
                state_next = S_M2;
            end
            S_M2:
            begin
                work_next  = mul_y;
                state_next = S_M3;
            end
            S_M3:
            begin
                work_next  = mul_y;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_next   = fp_add(acc_reg, work_reg);
                state_next = ent_reg.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_bits_next  = acc_reg;
                    acc_next       = 32'd0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        work_reg     <= work_next;
        out_bits_reg <= out_bits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.row_sum_bits = out_bits_reg;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import q6k_pkg::*;

    // Operation carried by one input item.
    typedef enum logic {
        OP_WRITE_BYTE = 1'b0,
        OP_ACTIVATION = 1'b1
    } q6k_op_t;

    // One input item as the driver presents it.
    typedef struct {
        q6k_op_t     op;
        logic [7:0]  byte_index;
        logic [7:0]  byte_value;
        logic [7:0]  element_index;
        logic [31:0] activation_bits;
        logic        last_of_row;
    } q6k_item_t;

    localparam int          BLOCK_BYTES = 210;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] POS_INF     = 32'h7F80_0000;

    logic clk;
    logic rst_n;

    q6k_in_if  in_ch ();
    q6k_out_if out_ch ();

    q6k_block_dot_product i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Items waiting to be offered, row sums still owed by the block.
    q6k_item_t   pending_items[$];
    logic [31:0] expected_sums[$];

    // Our own copy of the block state.
    logic [7:0]  weight_block[BLOCK_BYTES];
    logic [31:0] row_sum;

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int          error_count;

    // The clock runs with a 10 unit period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Rounds sign * mant * 2^exp to the nearest float32, ties to even.
    // The mantissa must not be zero.
    function automatic logic [31:0] round_to_single(input logic sgn, input int exp,
                                                    input logic [63:0] mant);
        int           msb;
        int           sh;
        int           ex;
        int           biased;
        logic [127:0] ext;
        logic [63:0]  kept;
        logic         rnd;
        logic         sticky;
        msb = 0;
        for (int k = 0; k < 64; k++)
        begin
            if (mant[k])
                msb = k;
        end
        sh = msb - 23;
        if (sh < -149 - exp)
            sh = -149 - exp;
        if (sh >= 0)
        begin
            ext    = {mant, 64'b0} >> ((sh > 127) ? 127 : sh);
            kept   = ext[127:64];
            rnd    = ext[63];
            sticky = |ext[62:0];
            if (rnd && (sticky || kept[0]))
                kept = kept + 64'd1;
        end
        else
        begin
            kept = mant << (-sh);
        end
        ex = exp + sh;
        if (kept[24])
        begin
            kept = kept >> 1;
            ex   = ex + 1;
        end
        if (!kept[23])
            return {sgn, 8'd0, kept[22:0]};
        biased = ex + 23 + 127;
        if (biased >= 255)
            return {sgn, POS_INF[30:0]};
        return {sgn, biased[7:0], kept[22:0]};
    endfunction

    // Splits a finite float32 into an integer mantissa and a power of two.
    function automatic void split_single(input logic [31:0] f, output logic [63:0] mant,
                                         output int exp);
        if (f[30:23] == 8'd0)
        begin
            mant = {41'b0, f[22:0]};
            exp  = -149;
        end
        else
        begin
            mant = {40'b0, 1'b1, f[22:0]};
            exp  = int'(f[30:23]) - 150;
        end
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return (&f[30:23]) && (|f[22:0]);
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return (&f[30:23]) && !(|f[22:0]);
    endfunction

    // A NaN operand passes through quieted, the left one first; an
    // invalid operation gives the default NaN.
    function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sgn;
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        sgn = a[31] ^ b[31];
        if (is_nan(a))
            return a | QUIET_BIT;
        if (is_nan(b))
            return b | QUIET_BIT;
        if (is_inf(a) || is_inf(b))
            return (a[30:0] == 0 || b[30:0] == 0) ? DEFAULT_NAN : {sgn, POS_INF[30:0]};
        if (a[30:0] == 0 || b[30:0] == 0)
            return {sgn, 31'b0};
        split_single(a, ma, ea);
        split_single(b, mb, eb);
        return round_to_single(sgn, ea + eb, ma * mb);
    endfunction

    function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lit;
        logic [63:0] mbig;
        logic [63:0] mlit;
        logic [63:0] total;
        int          ebig;
        int          elit;
        int          gap;
        int          exp;
        if (is_nan(a))
            return a | QUIET_BIT;
        if (is_nan(b))
            return b | QUIET_BIT;
        if (is_inf(a) && is_inf(b))
            return (a[31] != b[31]) ? DEFAULT_NAN : a;
        if (is_inf(a))
            return a;
        if (is_inf(b))
            return b;
        if (a[30:0] == 0 && b[30:0] == 0)
            return {a[31] & b[31], 31'b0};
        if (a[30:0] == 0)
            return b;
        if (b[30:0] == 0)
            return a;
        big = (a[30:0] >= b[30:0]) ? a : b;
        lit = (a[30:0] >= b[30:0]) ? b : a;
        split_single(big, mbig, ebig);
        split_single(lit, mlit, elit);
        gap = ebig - elit;
        if (gap > 38)
        begin
            // The small operand only matters as a sticky bit far below
            // the rounding position.
            mbig = mbig << 40;
            mlit = 64'd1;
            exp  = ebig - 40;
        end
        else
        begin
            mbig = mbig << gap;
            exp  = elit;
        end
        total = (a[31] != b[31]) ? mbig - mlit : mbig + mlit;
        if (total == 0)
            return 32'd0;
        return round_to_single(big[31], exp, total);
    endfunction

    // Exact widening of the fp16 super-scale.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        if (h[14:10] == 5'h1F)
            return {h[15], 8'hFF, h[9:0], 13'b0};
        if (h[14:10] == 5'd0)
            return (h[9:0] == 0) ? {h[15], 31'b0}
                                 : round_to_single(h[15], -24, {54'b0, h[9:0]});
        return {h[15], 3'b0, h[14:10] + 5'd0, 23'b0} + {1'b0, 8'd112, h[9:0], 13'b0};
    endfunction

    function automatic logic [31:0] int_to_single(input int v);
        if (v == 0)
            return 32'd0;
        return round_to_single(v < 0, 0, (v < 0) ? 64'(-v) : 64'(v));
    endfunction

    // Applies one accepted item to our copy of the block state.
    function automatic void predict_item(input q6k_item_t it);
        int          i;
        logic [7:0]  lo_byte;
        logic [7:0]  hi_byte;
        logic [3:0]  lo;
        logic [1:0]  hi;
        logic [31:0] d;
        logic [31:0] product;
        if (it.op == OP_WRITE_BYTE)
        begin
            if (it.byte_index < BLOCK_BYTES)
                weight_block[it.byte_index] = it.byte_value;
            return;
        end
        i       = it.element_index;
        lo_byte = weight_block[(i % 64) + 64 * (i / 128)];
        hi_byte = weight_block[QH_BASE + (i % 32) + 32 * (i / 128)];
        lo      = 4'(lo_byte >> (4 * ((i / 64) % 2)));
        hi      = 2'(hi_byte >> (2 * ((i / 32) % 4)));
        d       = widen_half({weight_block[D_HIGH], weight_block[D_BASE]});
        product = single_mul(d, int_to_single($signed(weight_block[SC_BASE + i / 16])));
        product = single_mul(product, int_to_single(int'({hi, lo}) - 32));
        product = single_mul(product, it.activation_bits);
        row_sum = single_add(row_sum, product);
        if (it.last_of_row)
        begin
            expected_sums.push_back(row_sum);
            row_sum = 32'd0;
        end
    endfunction

    // Driver: offers the next pending item unless this cycle idles.
    always @(posedge clk or negedge rst_n)
    begin
        q6k_item_t it;
        if (!rst_n)
        begin
            in_ch.valid           <= 1'b0;
            in_ch.func            <= 1'b0;
            in_ch.byte_index      <= 8'd0;
            in_ch.byte_value      <= 8'd0;
            in_ch.element_index   <= 8'd0;
            in_ch.activation_bits <= 32'd0;
            in_ch.last_of_row     <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                it.op              = q6k_op_t'(in_ch.func);
                it.byte_index      = in_ch.byte_index;
                it.byte_value      = in_ch.byte_value;
                it.element_index   = in_ch.element_index;
                it.activation_bits = in_ch.activation_bits;
                it.last_of_row     = in_ch.last_of_row;
                predict_item(it);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    it = pending_items.pop_front();
                    in_ch.valid           <= 1'b1;
                    in_ch.func            <= it.op;
                    in_ch.byte_index      <= it.byte_index;
                    in_ch.byte_value      <= it.byte_value;
                    in_ch.element_index   <= it.element_index;
                    in_ch.activation_bits <= it.activation_bits;
                    in_ch.last_of_row     <= it.last_of_row;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls at random and checks every accepted row sum.
    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("row_sum_bits: unexpected result %h", out_ch.row_sum_bits);
                    error_count++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (out_ch.row_sum_bits !== want)
                    begin
                        $error("row_sum_bits: expected %h, actual %h", want,
                               out_ch.row_sum_bits);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic q6k_item_t byte_write(input int idx, input logic [7:0] value);
        q6k_item_t it;
        it.op              = OP_WRITE_BYTE;
        it.byte_index      = idx[7:0];
        it.byte_value      = value;
        it.element_index   = 8'($urandom);
        it.activation_bits = $urandom;
        it.last_of_row     = 1'($urandom);
        return it;
    endfunction

    function automatic q6k_item_t activation(input int elem, input logic [31:0] x,
                                             input logic last);
        q6k_item_t it;
        it.op              = OP_ACTIVATION;
        it.byte_index      = 8'($urandom);
        it.byte_value      = 8'($urandom);
        it.element_index   = elem[7:0];
        it.activation_bits = x;
        it.last_of_row     = last;
        return it;
    endfunction

    // Mostly moderate activations, so sums stay finite; some raw patterns.
    function automatic logic [31:0] random_activation();
        if ($urandom_range(9) < 7)
            return {1'($urandom), 8'($urandom_range(150, 100)), 23'($urandom)};
        return $urandom;
    endfunction

    // Super-scale: usually a normal value near one, sometimes any pattern.
    function automatic logic [15:0] random_half();
        if ($urandom_range(9) < 8)
            return {1'($urandom), 5'($urandom_range(18, 10)), 10'($urandom)};
        return 16'($urandom);
    endfunction

    // Random part: rows of activations with block rewrites in between.
    task automatic queue_random(input int item_goal);
        int          made;
        int          row_len;
        logic [15:0] h;
        made = 0;
        while (made < item_goal)
        begin
            if ($urandom_range(3) == 0)
            begin
                repeat ($urandom_range(12, 1))
                begin
                    pending_items.push_back(byte_write($urandom_range(255), 8'($urandom)));
                    made++;
                end
            end
            if ($urandom_range(5) == 0)
            begin
                h = random_half();
                pending_items.push_back(byte_write(D_BASE, h[7:0]));
                pending_items.push_back(byte_write(D_HIGH, h[15:8]));
                made += 2;
            end
            row_len = $urandom_range(12, 1);
            for (int k = 0; k < row_len; k++)
            begin
                pending_items.push_back(activation($urandom_range(255), random_activation(),
                                                   k == row_len - 1));
                made++;
            end
        end
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && expected_sums.size() == 0 && !in_ch.valid);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        row_sum            = 32'd0;
        rst_n              = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Load the whole block first so no activation reads an empty byte.
        // Scales hit the signed extremes and zero; d starts at one.
        for (int b = 0; b < BLOCK_BYTES; b++)
        begin
            if (b == SC_BASE)
                pending_items.push_back(byte_write(b, 8'h80));
            else if (b == SC_BASE + 1)
                pending_items.push_back(byte_write(b, 8'h7F));
            else if (b == SC_BASE + 15)
                pending_items.push_back(byte_write(b, 8'h00));
            else if (b == D_BASE)
                pending_items.push_back(byte_write(b, 8'h00));
            else if (b == D_HIGH)
                pending_items.push_back(byte_write(b, 8'h3C));
            else if (b < QH_BASE && b % 2 == 0)
                pending_items.push_back(byte_write(b, 8'hFF));
            else
                pending_items.push_back(byte_write(b, 8'($urandom)));
        end

        // Element and activation extremes: negative zero, largest finite of both
        // signs, smallest subnormal, infinity and NaN.
        pending_items.push_back(activation(0, 32'h3F80_0000, 1'b0));
        pending_items.push_back(activation(255, 32'h8000_0000, 1'b1));
        pending_items.push_back(activation(16, 32'h7F7F_FFFF, 1'b0));
        pending_items.push_back(activation(17, 32'hFF7F_FFFF, 1'b1));
        pending_items.push_back(activation(128, 32'h0000_0001, 1'b1));
        pending_items.push_back(activation(64, 32'h7F80_0000, 1'b1));
        pending_items.push_back(activation(100, 32'h7FA0_0001, 1'b1));
        // Writes beyond the block are dropped, and their flag is ignored.
        pending_items.push_back(byte_write(210, 8'hAA));
        pending_items.push_back(byte_write(255, 8'h55));
        // Subnormal, infinite and NaN super-scales.
        pending_items.push_back(byte_write(D_BASE, 8'h01));
        pending_items.push_back(byte_write(D_HIGH, 8'h80));
        pending_items.push_back(activation(33, 32'h4000_0000, 1'b1));
        pending_items.push_back(byte_write(D_BASE, 8'h00));
        pending_items.push_back(byte_write(D_HIGH, 8'h7C));
        pending_items.push_back(activation(200, 32'h3F80_0000, 1'b0));
        pending_items.push_back(activation(250, 32'h0000_0000, 1'b1));
        pending_items.push_back(byte_write(D_BASE, 8'h01));
        pending_items.push_back(byte_write(D_HIGH, 8'hFE));
        pending_items.push_back(activation(5, 32'h3F80_0000, 1'b1));
        pending_items.push_back(byte_write(D_HIGH, 8'h3C));
        queue_random(350);
        drain();

        // The sender stays quiet between phases until every sum is back.
        sender_idle_pct = 58;
        queue_random(350);
        drain();

        sender_idle_pct    = 0;
        receiver_stall_pct = 58;
        queue_random(350);
        drain();

        sender_idle_pct    = 21;
        receiver_stall_pct = 21;
        queue_random(350);
        drain();

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
